// ===== sv/jlrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlrg_pkg
// shared constants, register codes and lane types of the reference generator
// ----------------------------------------------------------------------------
package jlrg_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam int FIELD_BITS    = 32;
    localparam int YAW_BITS      = 19;
    localparam int NF_BITS       = 21;
    localparam int ZETA_BITS     = 18;
    localparam int JERK_BITS     = 23;
    localparam int ACCEL_BITS    = 22;
    localparam int SPEED_BITS    = 21;
    localparam int LIM_BITS      = 23;
    localparam int NUM_LANES     = 3;

    // norm unit: magnitudes are brought below 2^31 before squaring
    localparam int NORM_MAG_BITS = 31;
    localparam int SUM_BITS      = 64;
    localparam int ROOT_STEPS    = 32;

    // multiply by the tick period: (|x| + 5) / 10
    localparam int TICK_RND      = 5;
    localparam int TICK_DIV      = 10;

    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 32;

    localparam logic [NF_BITS-1:0]    NF_RESET    = 21'd65536;
    localparam logic [ZETA_BITS-1:0]  ZETA_RESET  = 18'd49152;
    localparam logic [JERK_BITS-1:0]  JERK_RESET  = 23'd983040;
    localparam logic [ACCEL_BITS-1:0] ACCEL_RESET = 22'd327680;
    localparam logic [SPEED_BITS-1:0] SPEED_RESET = 21'd131072;

    typedef enum logic [2:0] {
        REG_NATURAL_FREQ  = 3'd0,
        REG_DAMPING_RATIO = 3'd1,
        REG_JERK_LIMIT    = 3'd2,
        REG_ACCEL_LIMIT   = 3'd3,
        REG_SPEED_LIMIT   = 3'd4
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_SNAP,
        OP_W2,
        OP_C,
        OP_E,
        OP_P1,
        OP_P2,
        OP_JK,
        OP_TKT,
        OP_TKA,
        OP_TKV,
        OP_DD,
        OP_ACC,
        OP_DP,
        OP_ZA,
        OP_VEL,
        OP_POS,
        OP_RS
    } lane_op_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

endpackage

// ===== sv/jerk_limited_reference_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jerk_limited_reference_generator_top
// jerk, acceleration and speed limited second-order position reference
// ----------------------------------------------------------------------------
// usage
//  - input channel (s_valid / s_ready): one control tick per transfer, with the
//    offboard flag, an optional new target and the measured pose
//  - result channel (m_valid / m_ready): one reference position and held yaw
//    per tick, taken from an output register
//  - apb port: five limit and filter registers at byte address 4*i, pready is
//    tied high, write only while the block is idle
//  - one tick at a time: s_ready is high only in the idle state
//  - offboard off: the snap state, then the output state loads the result register
//  - offboard on: three norm checks in the merge stage, a fourth when the speed
//    cap trips, up to three rescales in the lane dividers, and the sequencing
//    states that lead through them
//  - the square-root loop of the norm unit and the bit-serial lane dividers
//    take most of the time of such a tick
//  - reset zeroes the sequencer and lane motion state; registers take defaults
//  - when the receiver stalls, the finished result waits in the output
//    register and the next tick is taken; its result waits until that one leaves
// ----------------------------------------------------------------------------
module jerk_limited_reference_generator_top import jlrg_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // apb configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output logic [DATA_BITS-1:0]         prdata,
    output logic                         pready,
    // tick input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_offboard,
    input  logic                         s_new_target,
    input  logic signed [FIELD_BITS-1:0] s_target_x,
    input  logic signed [FIELD_BITS-1:0] s_target_y,
    input  logic signed [FIELD_BITS-1:0] s_target_z,
    input  logic signed [FIELD_BITS-1:0] s_meas_x,
    input  logic signed [FIELD_BITS-1:0] s_meas_y,
    input  logic signed [FIELD_BITS-1:0] s_meas_z,
    input  logic signed [YAW_BITS-1:0]   s_meas_yaw,
    // reference output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [FIELD_BITS-1:0] m_ref_x,
    output logic signed [FIELD_BITS-1:0] m_ref_y,
    output logic signed [FIELD_BITS-1:0] m_ref_z,
    output logic signed [YAW_BITS-1:0]   m_ref_yaw
);

    localparam int W = WORD_BITS;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SNAP, ST_W2, ST_C, ST_E, ST_P1, ST_P2, ST_JK,
        ST_N1, ST_R1, ST_TK1, ST_DD, ST_N2, ST_R2, ST_ACC, ST_TK2, ST_DP1,
        ST_N3, ST_ZA, ST_TK3, ST_DP2, ST_N4, ST_R4, ST_VEL, ST_TK4, ST_POS, ST_OUT
    } state_t;

    // configuration registers
    logic [NF_BITS-1:0]    nf_reg;
    logic [ZETA_BITS-1:0]  zeta_reg;
    logic [JERK_BITS-1:0]  jerk_reg;
    logic [ACCEL_BITS-1:0] accel_reg;
    logic [SPEED_BITS-1:0] speed_reg;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nf_reg    <= NF_RESET;
            zeta_reg  <= ZETA_RESET;
            jerk_reg  <= JERK_RESET;
            accel_reg <= ACCEL_RESET;
            speed_reg <= SPEED_RESET;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_NATURAL_FREQ:  nf_reg    <= pwdata[NF_BITS-1:0];
                REG_DAMPING_RATIO: zeta_reg  <= pwdata[ZETA_BITS-1:0];
                REG_JERK_LIMIT:    jerk_reg  <= pwdata[JERK_BITS-1:0];
                REG_ACCEL_LIMIT:   accel_reg <= pwdata[ACCEL_BITS-1:0];
                REG_SPEED_LIMIT:   speed_reg <= pwdata[SPEED_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_NATURAL_FREQ:  prdata = DATA_BITS'(nf_reg);
            REG_DAMPING_RATIO: prdata = DATA_BITS'(zeta_reg);
            REG_JERK_LIMIT:    prdata = DATA_BITS'(jerk_reg);
            REG_ACCEL_LIMIT:   prdata = DATA_BITS'(accel_reg);
            REG_SPEED_LIMIT:   prdata = DATA_BITS'(speed_reg);
            default:           prdata = '0;
        endcase
    end

    // sequencer state and registered outputs
    state_t                      state_reg, state_next;
    logic                        started_reg, started_next;
    logic signed [FIELD_BITS-1:0] meas_reg [NUM_LANES];
    logic signed [FIELD_BITS-1:0] meas_next [NUM_LANES];
    logic signed [YAW_BITS-1:0]  yaw_in_reg, yaw_in_next;
    logic signed [YAW_BITS-1:0]  yaw_hold_reg, yaw_hold_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [FIELD_BITS-1:0] ref_x_reg, ref_x_next, ref_y_reg, ref_y_next;
    logic signed [FIELD_BITS-1:0] ref_z_reg, ref_z_next;
    logic signed [YAW_BITS-1:0]  ref_yaw_reg, ref_yaw_next;

    lane_op_t                    op;
    logic [LIM_BITS-1:0]         lim_sel;
    logic                        norm_start;
    logic                        norm_done;
    logic [W:0]                  nrm;
    logic                        over;
    logic                        in_xfer;
    logic                        lanes_done;

    logic signed [FIELD_BITS-1:0] tgt [NUM_LANES];
    logic signed [W-1:0]          lane_t [NUM_LANES];
    logic signed [FIELD_BITS-1:0] lane_ref [NUM_LANES];
    lane_stat_t                   lane_stat [NUM_LANES];

    assign tgt[0] = s_target_x;
    assign tgt[1] = s_target_y;
    assign tgt[2] = s_target_z;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_xfer    = s_valid && s_ready;
    assign lanes_done = lane_stat[0].done && lane_stat[1].done && lane_stat[2].done;

    // limit used by the current norm check or rescale
    always_comb begin
        case (state_reg)
            ST_N1, ST_R1: lim_sel = LIM_BITS'(jerk_reg);
            ST_N2, ST_R2: lim_sel = LIM_BITS'(accel_reg);
            default:      lim_sel = LIM_BITS'(speed_reg);
        endcase
    end

    assign over = nrm > (W + 1)'(lim_sel);

    always_comb begin
        state_next    = state_reg;
        started_next  = started_reg;
        meas_next     = meas_reg;
        yaw_in_next   = yaw_in_reg;
        yaw_hold_next = yaw_hold_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ref_x_next    = ref_x_reg;
        ref_y_next    = ref_y_reg;
        ref_z_next    = ref_z_reg;
        ref_yaw_next  = ref_yaw_reg;
        op            = OP_NOP;
        norm_start    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    // goal is loaded first; snap overwrites it when offboard is off
                    if (s_new_target) op = OP_LOAD;
                    meas_next[0] = s_meas_x;
                    meas_next[1] = s_meas_y;
                    meas_next[2] = s_meas_z;
                    yaw_in_next  = s_meas_yaw;
                    state_next   = s_offboard ? ST_W2 : ST_SNAP;
                end
            end
            ST_SNAP: begin
                op            = OP_SNAP;
                yaw_hold_next = yaw_in_reg;
                state_next    = ST_OUT;
            end
            ST_W2:  begin op = OP_W2;  state_next = ST_C;  end
            ST_C:   begin op = OP_C;   state_next = ST_E;  end
            ST_E:   begin op = OP_E;   state_next = ST_P1; end
            ST_P1:  begin op = OP_P1;  state_next = ST_P2; end
            ST_P2:  begin op = OP_P2;  state_next = ST_JK; end
            ST_JK:  begin op = OP_JK;  state_next = ST_N1; end
            ST_N1, ST_N2, ST_N3, ST_N4: begin
                // start the norm on entry, branch when it reports
                if (!started_reg) begin
                    norm_start   = 1'b1;
                    started_next = 1'b1;
                end else if (norm_done) begin
                    started_next = 1'b0;
                    case (state_reg)
                        ST_N1:   state_next = over ? ST_R1 : ST_TK1;
                        ST_N2:   state_next = over ? ST_R2 : ST_ACC;
                        ST_N3:   state_next = over ? ST_ZA : ST_VEL;
                        default: state_next = ST_R4;
                    endcase
                end
            end
            ST_R1, ST_R2, ST_R4: begin
                if (!started_reg) begin
                    op           = OP_RS;
                    started_next = 1'b1;
                end else if (lanes_done) begin
                    started_next = 1'b0;
                    case (state_reg)
                        ST_R1:   state_next = ST_TK1;
                        ST_R2:   state_next = ST_ACC;
                        default: state_next = ST_VEL;
                    endcase
                end
            end
            ST_TK1: begin op = OP_TKT; state_next = ST_DD;  end
            ST_DD:  begin op = OP_DD;  state_next = ST_N2;  end
            ST_ACC: begin op = OP_ACC; state_next = ST_TK2; end
            ST_TK2: begin op = OP_TKT; state_next = ST_DP1; end
            ST_DP1: begin op = OP_DP;  state_next = ST_N3;  end
            ST_ZA:  begin op = OP_ZA;  state_next = ST_TK3; end
            ST_TK3: begin op = OP_TKA; state_next = ST_DP2; end
            ST_DP2: begin op = OP_DP;  state_next = ST_N4;  end
            ST_VEL: begin op = OP_VEL; state_next = ST_TK4; end
            ST_TK4: begin op = OP_TKV; state_next = ST_POS; end
            ST_POS: begin op = OP_POS; state_next = ST_OUT; end
            ST_OUT: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    ref_x_next   = lane_ref[0];
                    ref_y_next   = lane_ref[1];
                    ref_z_next   = lane_ref[2];
                    ref_yaw_next = yaw_hold_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            started_reg  <= 1'b0;
            yaw_hold_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            started_reg  <= started_next;
            yaw_hold_reg <= yaw_hold_next;
            m_valid_reg  <= m_valid_next;
        end
        meas_reg    <= meas_next;
        yaw_in_reg  <= yaw_in_next;
        ref_x_reg   <= ref_x_next;
        ref_y_reg   <= ref_y_next;
        ref_z_reg   <= ref_z_next;
        ref_yaw_reg <= ref_yaw_next;
    end

    // one lane per axis
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        jlrg_lane #(
            .W (WORD_BITS),
            .F (FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .op      (op),
            .nf      (nf_reg),
            .zeta    (zeta_reg),
            .lim     (lim_sel),
            .nrm     (nrm),
            .target  (tgt[g]),
            .meas    (meas_reg[g]),
            .t_out   (lane_t[g]),
            .ref_out (lane_ref[g]),
            .stat    (lane_stat[g])
        );
    end

    // merge stage: norm over the three lane values
    jlrg_norm #(
        .W (WORD_BITS)
    ) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .vec     (lane_t),
        .nrm     (nrm),
        .done    (norm_done)
    );

    assign m_valid   = m_valid_reg;
    assign m_ref_x   = ref_x_reg;
    assign m_ref_y   = ref_y_reg;
    assign m_ref_z   = ref_z_reg;
    assign m_ref_yaw = ref_yaw_reg;

endmodule

// ===== sv/jlrg_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlrg_lane
// one axis of the filter: state, shared multiplier, tick scaling and divider
// ----------------------------------------------------------------------------
module jlrg_lane import jlrg_pkg::*; #(
    parameter int W = WORD_BITS_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lane_op_t                     op,
    input  logic [NF_BITS-1:0]           nf,
    input  logic [ZETA_BITS-1:0]         zeta,
    input  logic [LIM_BITS-1:0]          lim,
    input  logic [W:0]                   nrm,
    input  logic signed [FIELD_BITS-1:0] target,
    input  logic signed [FIELD_BITS-1:0] meas,
    output logic signed [W-1:0]          t_out,
    output logic signed [FIELD_BITS-1:0] ref_out,
    output lane_stat_t                   stat
);

    localparam int MW   = 2 * W + 2;
    localparam int NB   = W + 1;
    localparam int NUMW = W + LIM_BITS;
    localparam int CW   = $clog2(NUMW + 1);
    localparam int K    = W + 4;
    localparam longint unsigned RCP_L = (64'd1 << K) / 64'd10;
    localparam logic [W:0] RCP = (W + 1)'(RCP_L);
    localparam logic [MW-1:0] CAP_POS = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [MW-1:0] CAP_NEG = CAP_POS + 1'b1;
    localparam logic [MW-1:0] HALF = MW'(1) << (F - 1);
    localparam longint WMAX_L = (longint'(1) << (W - 1)) - 1;
    localparam longint WMIN_L = -WMAX_L - 1;
    localparam longint I32MAX = 64'sd2147483647;
    localparam longint I32MIN = -64'sd2147483648;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        logic [W-1:0] u;
        u = v;
        mag = v[W-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [MW-1:0] m);
        logic [MW-1:0] c;
        logic [MW-1:0] mm;
        c  = neg ? CAP_NEG : CAP_POS;
        mm = (m > c) ? c : m;
        from_mag = neg ? W'(~mm + 1'b1) : W'(mm);
    endfunction

    function automatic logic signed [W-1:0] sat_sum(input logic [W:0] s);
        if (s[W] != s[W-1]) sat_sum = {s[W], {(W - 1){~s[W]}}};
        else sat_sum = s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] add_sat(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        add_sat = sat_sum({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic logic signed [W-1:0] sub_sat(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        sub_sat = sat_sum({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic logic signed [W-1:0] times10(input logic signed [W-1:0] x);
        logic [MW-1:0] m;
        m = MW'(mag(x));
        times10 = from_mag(x[W-1], (m << 3) + (m << 1));
    endfunction

    function automatic logic signed [W-1:0] sat_in(input logic signed [FIELD_BITS-1:0] v);
        longint v64;
        v64 = {{(64 - FIELD_BITS){v[FIELD_BITS-1]}}, v};
        if (v64 > WMAX_L) v64 = WMAX_L;
        if (v64 < WMIN_L) v64 = WMIN_L;
        sat_in = W'(v64);
    endfunction

    logic signed [W-1:0] goal_reg, goal_next, pos_reg, pos_next;
    logic signed [W-1:0] vel_reg, vel_next, acc_reg, acc_next;
    logic signed [W-1:0] e_reg, e_next, t_reg, t_next, p_reg, p_next;
    logic signed [W-1:0] w2_reg, w2_next, c_reg, c_next, tk_reg, tk_next;
    logic [NUMW-1:0]     num_reg, num_next;
    logic [NB:0]         rem_reg, rem_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic                busy_reg, busy_next, done_reg, done_next;

    logic [W-1:0]        mul_a, mul_b;
    logic                mul_neg;
    logic [2*W-1:0]      prod;
    logic signed [W-1:0] fm_res;
    logic signed [W-1:0] tick_src;
    logic [W:0]          tk_m, tk_q0, tk_rem, tk_q;
    logic [2*W+1:0]      tk_prod;
    logic signed [W-1:0] tk_res;
    logic [NB:0]         rem_sh;
    logic                div_ge;
    logic                toward;
    longint              pos64;

    // operand select for the shared multiplier and the tick scaler
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        mul_neg  = 1'b0;
        tick_src = t_reg;
        case (op)
            OP_W2: begin
                mul_a = W'(nf);
                mul_b = W'(nf);
            end
            OP_C: begin
                mul_a = W'({zeta, 1'b0});
                mul_b = W'(nf);
            end
            OP_P1: begin
                mul_a   = mag(w2_reg);
                mul_b   = mag(e_reg);
                mul_neg = w2_reg[W-1] ^ e_reg[W-1];
            end
            OP_P2: begin
                mul_a   = mag(c_reg);
                mul_b   = mag(vel_reg);
                mul_neg = c_reg[W-1] ^ vel_reg[W-1];
            end
            OP_RS: begin
                mul_a = mag(t_reg);
                mul_b = W'(lim);
            end
            OP_TKA:  tick_src = acc_reg;
            OP_TKV:  tick_src = vel_reg;
            default: tick_src = t_reg;
        endcase
    end

    assign prod   = (2 * W)'(mul_a) * (2 * W)'(mul_b);
    assign fm_res = from_mag(mul_neg, (MW'(prod) + HALF) >> F);

    // divide by ten via reciprocal, one correction step
    assign tk_m    = (W + 1)'(mag(tick_src)) + (W + 1)'(TICK_RND);
    assign tk_prod = (2 * W + 2)'(tk_m) * (2 * W + 2)'(RCP);
    assign tk_q0   = (W + 1)'(tk_prod >> K);
    assign tk_rem  = tk_m - ((tk_q0 << 3) + (tk_q0 << 1));
    assign tk_q    = (tk_rem >= (W + 1)'(TICK_DIV)) ? tk_q0 + 1'b1 : tk_q0;
    assign tk_res  = from_mag(tick_src[W-1], MW'(tk_q));

    assign rem_sh = {rem_reg[NB-1:0], num_reg[NUMW-1]};
    assign div_ge = rem_sh >= {1'b0, nrm};
    assign toward = (!vel_reg[W-1] && vel_reg != '0 && !e_reg[W-1] && e_reg != '0) ||
                    (vel_reg[W-1] && e_reg[W-1]);

    always_comb begin
        goal_next = goal_reg;
        pos_next  = pos_reg;
        vel_next  = vel_reg;
        acc_next  = acc_reg;
        e_next    = e_reg;
        t_next    = t_reg;
        p_next    = p_reg;
        w2_next   = w2_reg;
        c_next    = c_reg;
        tk_next   = tk_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            rem_next = div_ge ? rem_sh - {1'b0, nrm} : rem_sh;
            num_next = {num_reg[NUMW-2:0], div_ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                t_next    = from_mag(neg_reg, MW'({num_reg[NUMW-2:0], div_ge}));
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        case (op)
            OP_LOAD: goal_next = sat_in(target);
            OP_SNAP: begin
                goal_next = sat_in(meas);
                pos_next  = sat_in(meas);
                vel_next  = '0;
                acc_next  = '0;
            end
            OP_W2:  w2_next = fm_res;
            OP_C:   c_next  = fm_res;
            OP_E:   e_next  = sub_sat(goal_reg, pos_reg);
            OP_P1:  p_next  = fm_res;
            OP_P2:  t_next  = sub_sat(p_reg, fm_res);
            OP_JK:  t_next  = times10(sub_sat(t_reg, acc_reg));
            OP_TKT, OP_TKA, OP_TKV: tk_next = tk_res;
            OP_DD:  t_next  = add_sat(acc_reg, tk_reg);
            OP_ACC: acc_next = t_reg;
            OP_DP:  t_next  = add_sat(vel_reg, tk_reg);
            OP_ZA:  if (toward) acc_next = '0;
            OP_VEL: vel_next = t_reg;
            OP_POS: pos_next = add_sat(pos_reg, tk_reg);
            OP_RS: begin
                if (nrm == '0) begin
                    t_next    = '0;
                    done_next = 1'b1;
                end else begin
                    num_next  = NUMW'(prod);
                    rem_next  = '0;
                    cnt_next  = CW'(NUMW);
                    neg_next  = t_reg[W-1];
                    busy_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_reg <= '0;
            pos_reg  <= '0;
            vel_reg  <= '0;
            acc_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            goal_reg <= goal_next;
            pos_reg  <= pos_next;
            vel_reg  <= vel_next;
            acc_reg  <= acc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        e_reg   <= e_next;
        t_reg   <= t_next;
        p_reg   <= p_next;
        w2_reg  <= w2_next;
        c_reg   <= c_next;
        tk_reg  <= tk_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    always_comb begin
        pos64 = {{(64 - W){pos_reg[W-1]}}, pos_reg};
        if (pos64 > I32MAX) pos64 = I32MAX;
        if (pos64 < I32MIN) pos64 = I32MIN;
    end

    assign ref_out   = FIELD_BITS'(pos64);
    assign t_out     = t_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/jlrg_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlrg_norm
// merge stage: euclidean norm of the three lane values, serial square root
// ----------------------------------------------------------------------------
module jlrg_norm import jlrg_pkg::*; #(
    parameter int W = WORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] vec [NUM_LANES],
    output logic [W:0]          nrm,
    output logic                done
);

    localparam int SMAX = (W > NORM_MAG_BITS) ? W - NORM_MAG_BITS : 0;
    localparam int SW   = $clog2(SMAX + 2);
    localparam logic [SUM_BITS-1:0] LIMIT = SUM_BITS'(1) << NORM_MAG_BITS;
    localparam logic [SUM_BITS-1:0] TOP_BIT = SUM_BITS'(1) << (SUM_BITS - 2);

    typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_OUT} nstate_t;

    nstate_t                  state_reg, state_next;
    logic [NORM_MAG_BITS-1:0] sq_reg [NUM_LANES];
    logic [NORM_MAG_BITS-1:0] sq_next [NUM_LANES];
    logic [SW-1:0]            s_reg, s_next;
    logic [2*NORM_MAG_BITS-1:0] prod_reg, prod_next;
    logic [SUM_BITS-1:0]      acc_reg, acc_next, x_reg, x_next, r_reg, r_next;
    logic [SUM_BITS-1:0]      bit_reg, bit_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic [W:0]               nrm_reg, nrm_next;
    logic                     done_reg, done_next;

    logic [W-1:0]             mags [NUM_LANES];
    logic [W-1:0]             mx;
    logic [SW-1:0]            s_find;
    logic [1:0]               idx;
    logic [SUM_BITS-1:0]      trial;

    always_comb begin
        mx = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            mags[i] = vec[i][W-1] ? (~vec[i] + 1'b1) : vec[i];
            if (mags[i] > mx) mx = mags[i];
        end
        s_find = SW'(SMAX);
        for (int i = SMAX; i >= 0; i--) begin
            if ((SUM_BITS'(mx) >> i) < LIMIT) s_find = SW'(i);
        end
    end

    assign idx   = (cnt_reg[1:0] == 2'd3) ? 2'd0 : cnt_reg[1:0];
    assign trial = r_reg + bit_reg;

    always_comb begin
        state_next = state_reg;
        sq_next    = sq_reg;
        s_next     = s_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        nrm_next   = nrm_reg;
        done_next  = 1'b0;
        case (state_reg)
            N_IDLE: if (start) state_next = N_SHIFT;
            N_SHIFT: begin
                for (int i = 0; i < NUM_LANES; i++)
                    sq_next[i] = NORM_MAG_BITS'(SUM_BITS'(mags[i]) >> s_find);
                s_next     = s_find;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = N_SQ;
            end
            N_SQ: begin
                // square one lane per cycle, accumulate its product in the next cycle
                prod_next = (2 * NORM_MAG_BITS)'(sq_reg[idx]) *
                            (2 * NORM_MAG_BITS)'(sq_reg[idx]);
                acc_next  = acc_reg + SUM_BITS'(prod_reg);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 5'd0) acc_next = '0;
                if (cnt_reg == 5'd3) begin
                    x_next     = acc_reg + SUM_BITS'(prod_reg);
                    r_next     = '0;
                    bit_next   = TOP_BIT;
                    cnt_next   = '0;
                    state_next = N_ROOT;
                end
            end
            N_ROOT: begin
                if (x_reg >= trial) begin
                    x_next = x_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end else begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(ROOT_STEPS - 1)) state_next = N_OUT;
            end
            N_OUT: begin
                nrm_next   = (W + 1)'(r_reg << s_reg);
                done_next  = 1'b1;
                state_next = N_IDLE;
            end
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        sq_reg   <= sq_next;
        s_reg    <= s_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        cnt_reg  <= cnt_next;
        nrm_reg  <= nrm_next;
    end

    assign nrm  = nrm_reg;
    assign done = done_reg;

endmodule
